// ===== rtl/core/tlpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpr_pkg
// Shared types and constants of the text line pixel renderer.
// ----------------------------------------------------------------------------
package tlpr_pkg;

  // action codes
  localparam logic [1:0] ACT_RENDER     = 2'd0;
  localparam logic [1:0] ACT_LOAD_CHAR  = 2'd1;
  localparam logic [1:0] ACT_LOAD_GLYPH = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_COLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_BG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRING_LENGTH    = 3'd5;

  // glyph rows held per glyph, each 8 bits wide
  localparam int ROWS_STORED = 8;

  // widest string index and glyph column over the parameter ranges
  localparam int IDX_MAX_W = 8;
  localparam int COL_MAX_W = 5;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] scanline;
    logic signed [15:0] x_pos;
    logic signed [15:0] window_start;
    logic [12:0]        window_width;
    logic [5:0]         char_slot;
    logic [7:0]         char_code;
    logic [2:0]         glyph_row;
    logic [7:0]         glyph_bits;
  } tlpr_in_t;

  typedef struct packed {
    logic        write_pixel;
    logic [15:0] pixel_color;
  } tlpr_out_t;

  typedef struct packed {
    logic signed [15:0] x_origin;
    logic signed [15:0] y_origin;
    logic [15:0]        text_color;
    logic [15:0]        background_color;
    logic               transparent_bg;
    logic [6:0]         string_length;
  } tlpr_cfg_t;

  // store update carried down the pipe to the stage that owns each store
  typedef struct packed {
    logic       ld_char;
    logic       ld_glyph;
    logic [5:0] slot;
    logic [7:0] code;
    logic [2:0] grow;
    logic [7:0] gbits;
  } tlpr_load_t;

  typedef struct packed {
    logic                 hit;
    logic                 row_ok;
    logic [2:0]           row;
    logic [IDX_MAX_W-1:0] idx;
    logic [COL_MAX_W-1:0] col;
    tlpr_load_t           load;
  } tlpr_hit_t;

endpackage

// ===== rtl/core/tlpr_cfg.sv =====
// ----------------------------------------------------------------------------
// tlpr_cfg
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module tlpr_cfg
  import tlpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output tlpr_cfg_t             cfg
);

  tlpr_cfg_t cfg_r;
  tlpr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_X_ORIGIN:         cfg_nxt.x_origin         = cfg_wdata;
        CFG_Y_ORIGIN:         cfg_nxt.y_origin         = cfg_wdata;
        CFG_TEXT_COLOR:       cfg_nxt.text_color       = cfg_wdata;
        CFG_BACKGROUND_COLOR: cfg_nxt.background_color = cfg_wdata;
        CFG_TRANSPARENT_BG:   cfg_nxt.transparent_bg   = cfg_wdata[0];
        CFG_STRING_LENGTH:    cfg_nxt.string_length    = cfg_wdata[6:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin         <= '0;
      cfg_r.y_origin         <= '0;
      cfg_r.text_color       <= '0;
      cfg_r.background_color <= '0;
      cfg_r.transparent_bg   <= 1'b1;
      cfg_r.string_length    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/tlpr_geom.sv =====
// ----------------------------------------------------------------------------
// tlpr_geom
// Three-stage geometry front end: offsets, box and strip tests, and the split
// of the string-relative x into character index and glyph column.
// ----------------------------------------------------------------------------
module tlpr_geom
  import tlpr_pkg::*;
#(
  parameter int MAX_CHARS = 64,
  parameter int CHAR_W    = 8,
  parameter int CHAR_H    = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tlpr_cfg_t cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  tlpr_in_t  in_data,
  output logic      hit_valid,
  input  logic      hit_ready,
  output tlpr_hit_t hit_data
);

  localparam int LEN_W   = $clog2(MAX_CHARS + 1);
  localparam int REL_W   = (MAX_CHARS * CHAR_W > 1) ? $clog2(MAX_CHARS * CHAR_W) : 1;
  localparam int L_W     = $clog2(CHAR_W);
  localparam int SHIFT   = REL_W + L_W;
  localparam int PROD_W  = 2 * REL_W + 1;
  localparam int RECIP   = ((1 << SHIFT) + CHAR_W - 1) / CHAR_W;
  localparam int IDX_W   = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int COL_W   = (CHAR_W > 1) ? $clog2(CHAR_W) : 1;

  logic en1, en2, en3;

  // stage 1: offsets against origin and strip
  logic               s1_v_r;
  logic               s1_render_r;
  logic signed [16:0] s1_row_r,  s1_row_nxt;
  logic signed [16:0] s1_rel_r,  s1_rel_nxt;
  logic signed [16:0] s1_wrel_r, s1_wrel_nxt;
  logic [12:0]        s1_wwidth_r;
  logic [LEN_W-1:0]   s1_len_r,  s1_len_nxt;
  tlpr_load_t         s1_load_r, s1_load_nxt;

  // stage 2: window tests and quotient
  logic               s2_v_r;
  logic               s2_hit_r, s2_hit_nxt;
  logic [REL_W-1:0]   s2_rel_r;
  logic [IDX_W-1:0]   s2_idx_r, s2_idx_nxt;
  logic               s2_row_lt8_r;
  logic [2:0]         s2_row_r;
  tlpr_load_t         s2_load_r;
  logic [16:0]        s2_span;
  logic               row_ok, x_ok, w_ok;
  logic [REL_W-1:0]   rel_n;
  logic [PROD_W-1:0]  prod;

  // stage 3: remainder
  logic               s3_v_r;
  tlpr_hit_t          s3_r, s3_nxt;
  logic [REL_W-1:0]   col_full;

  assign en3      = !s3_v_r || hit_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  assign s1_row_nxt  = {in_data.scanline[15], in_data.scanline}
                     - {cfg.y_origin[15], cfg.y_origin};
  assign s1_rel_nxt  = {in_data.x_pos[15], in_data.x_pos}
                     - {cfg.x_origin[15], cfg.x_origin};
  assign s1_wrel_nxt = {in_data.x_pos[15], in_data.x_pos}
                     - {in_data.window_start[15], in_data.window_start};
  assign s1_len_nxt  = (int'(cfg.string_length) > MAX_CHARS) ? LEN_W'(MAX_CHARS)
                                                             : LEN_W'(cfg.string_length);

  always_comb begin
    s1_load_nxt.ld_char  = (in_data.action == ACT_LOAD_CHAR) &&
                           (int'(in_data.char_slot) < MAX_CHARS);
    s1_load_nxt.ld_glyph = (in_data.action == ACT_LOAD_GLYPH);
    s1_load_nxt.slot     = in_data.char_slot;
    s1_load_nxt.code     = in_data.char_code;
    s1_load_nxt.grow     = in_data.glyph_row;
    s1_load_nxt.gbits    = in_data.glyph_bits;
  end

  // string box width in pixels
  assign s2_span    = 17'(int'(s1_len_r) * CHAR_W);
  assign row_ok     = !s1_row_r[16] && (s1_row_r[15:0] < 16'(CHAR_H));
  assign x_ok       = !s1_rel_r[16] && ({1'b0, s1_rel_r[15:0]} < s2_span);
  assign w_ok       = !s1_wrel_r[16] && (s1_wrel_r[15:0] < {3'b000, s1_wwidth_r});
  assign s2_hit_nxt = s1_render_r && row_ok && x_ok && w_ok;

  // divide by the glyph width through an exact reciprocal
  assign rel_n      = s1_rel_r[REL_W-1:0];
  assign prod       = PROD_W'(rel_n) * PROD_W'(RECIP);
  assign s2_idx_nxt = prod[SHIFT +: IDX_W];

  assign col_full = s2_rel_r - REL_W'(int'(s2_idx_r) * CHAR_W);

  always_comb begin
    s3_nxt.hit    = s2_hit_r;
    s3_nxt.row_ok = s2_row_lt8_r;
    s3_nxt.row    = s2_row_r;
    s3_nxt.idx    = IDX_MAX_W'(s2_idx_r);
    s3_nxt.col    = COL_MAX_W'(col_full[COL_W-1:0]);
    s3_nxt.load   = s2_load_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_render_r <= (in_data.action == ACT_RENDER);
      s1_row_r    <= s1_row_nxt;
      s1_rel_r    <= s1_rel_nxt;
      s1_wrel_r   <= s1_wrel_nxt;
      s1_wwidth_r <= in_data.window_width;
      s1_len_r    <= s1_len_nxt;
      s1_load_r   <= s1_load_nxt;
    end
    if (en2) begin
      s2_hit_r     <= s2_hit_nxt;
      s2_rel_r     <= rel_n;
      s2_idx_r     <= s2_idx_nxt;
      s2_row_lt8_r <= (s1_row_r[15:0] < 16'(ROWS_STORED));
      s2_row_r     <= s1_row_r[2:0];
      s2_load_r    <= s1_load_r;
    end
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

  assign hit_valid = s3_v_r;
  assign hit_data  = s3_r;

endmodule

// ===== rtl/core/tlpr_fetch.sv =====
// ----------------------------------------------------------------------------
// tlpr_fetch
// String and glyph stores, each read and written in its own pipeline stage,
// and the registered pixel result.
// ----------------------------------------------------------------------------
module tlpr_fetch
  import tlpr_pkg::*;
#(
  parameter int MAX_CHARS   = 64,
  parameter int GLYPH_COUNT = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tlpr_cfg_t cfg,
  input  logic      hit_valid,
  output logic      hit_ready,
  input  tlpr_hit_t hit_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tlpr_out_t out_data
);

  localparam int IDX_W       = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int GC_W        = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int GA_W        = GC_W + $clog2(ROWS_STORED);
  localparam int GLYPH_DEPTH = GLYPH_COUNT * ROWS_STORED;

  logic en4, en5, en6;

  logic [7:0] str_mem   [MAX_CHARS];
  logic [7:0] glyph_mem [GLYPH_DEPTH];

  // stage 4: character code
  logic       s4_v_r;
  tlpr_hit_t  s4_meta_r;
  logic [7:0] s4_code_r;

  // stage 5: glyph row
  logic                 s5_v_r;
  logic                 s5_hit_r;
  logic                 s5_bits_ok_r;
  logic [COL_MAX_W-1:0] s5_col_r;
  logic [7:0]           s5_bits_r;
  logic                 code_ok;
  logic                 gwr_ok;
  logic [GA_W-1:0]      g_rd_addr;
  logic [GA_W-1:0]      g_wr_addr;

  // stage 6: result word
  logic      out_v_r;
  tlpr_out_t out_r, out_nxt;
  logic      pix_bit;

  assign en6       = !out_v_r || out_ready;
  assign en5       = !s5_v_r || en6;
  assign en4       = !s4_v_r || en5;
  assign hit_ready = en4;

  always_ff @(posedge clk) begin
    if (en4 && hit_valid) begin
      if (hit_data.load.ld_char) begin
        str_mem[IDX_W'(hit_data.load.slot)] <= hit_data.load.code;
      end
      s4_code_r <= str_mem[hit_data.idx[IDX_W-1:0]];
    end
  end

  assign code_ok   = int'(s4_code_r) < GLYPH_COUNT;
  assign gwr_ok    = s4_meta_r.load.ld_glyph && (int'(s4_meta_r.load.code) < GLYPH_COUNT);
  assign g_rd_addr = {s4_code_r[GC_W-1:0], s4_meta_r.row};
  assign g_wr_addr = {s4_meta_r.load.code[GC_W-1:0], s4_meta_r.load.grow};

  always_ff @(posedge clk) begin
    if (en5 && s4_v_r) begin
      if (gwr_ok) begin
        glyph_mem[g_wr_addr] <= s4_meta_r.load.gbits;
      end
      s5_bits_r <= glyph_mem[g_rd_addr];
    end
  end

  // bit 0 of a glyph row is the leftmost pixel; columns past the row are clear
  assign pix_bit = s5_bits_ok_r && (s5_col_r < COL_MAX_W'(8)) && s5_bits_r[s5_col_r[2:0]];

  always_comb begin
    out_nxt.write_pixel = s5_hit_r && (pix_bit || !cfg.transparent_bg);
    if (!out_nxt.write_pixel) begin
      out_nxt.pixel_color = '0;
    end else if (pix_bit) begin
      out_nxt.pixel_color = cfg.text_color;
    end else begin
      out_nxt.pixel_color = cfg.background_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en4) s4_v_r  <= hit_valid;
      if (en5) s5_v_r  <= s4_v_r;
      if (en6) out_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_meta_r <= hit_data;
    end
    if (en5) begin
      s5_hit_r     <= s4_meta_r.hit;
      s5_bits_ok_r <= code_ok && s4_meta_r.row_ok;
      s5_col_r     <= s4_meta_r.col;
    end
    if (en6) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/text_line_pixel_renderer.sv =====
// Six register stages lie between the input and out_data.
// Throughput: one word accepted per cycle. A stalled output first lets empty stages fill,
// and holds in_ready low only once all six stages hold a word.
// Synchronous active-low reset clears all valid bits and the config registers
// (transparent_bg to 1); string and glyph stores are not cleared and hold
// garbage until loaded, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// text_line_pixel_renderer
// Bitmap font character generator for one horizontal text string.
// ----------------------------------------------------------------------------
module text_line_pixel_renderer
  import tlpr_pkg::*;
#(
  parameter int MAX_CHARS   = 64,
  parameter int CHAR_W      = 8,
  parameter int CHAR_H      = 8,
  parameter int GLYPH_COUNT = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tlpr_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tlpr_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tlpr_cfg_t cfg;
  logic      hit_valid;
  logic      hit_ready;
  tlpr_hit_t hit_data;

  tlpr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tlpr_geom #(
    .MAX_CHARS (MAX_CHARS),
    .CHAR_W    (CHAR_W),
    .CHAR_H    (CHAR_H)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .hit_data  (hit_data)
  );

  tlpr_fetch #(
    .MAX_CHARS   (MAX_CHARS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .hit_valid (hit_valid),
    .hit_ready (hit_ready),
    .hit_data  (hit_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text line pixel renderer. Drives string and
// glyph loads and pixel requests through the valid/ready input, predicts each
// result word from its own copy of the registers and stores, and checks every
// result word in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import tlpr_pkg::*;

  localparam int MAX_CHARS   = 64;
  localparam int CHAR_W      = 8;
  localparam int CHAR_H      = 8;
  localparam int GLYPH_COUNT = 256;
  localparam int LATENCY     = 6;
  localparam int TIMEOUT_NS  = 4_000_000;

  // action code the block leaves undefined
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  tlpr_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tlpr_out_t out_data;
  logic      cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  text_line_pixel_renderer #(
    .MAX_CHARS  (MAX_CHARS),
    .CHAR_W     (CHAR_W),
    .CHAR_H     (CHAR_H),
    .GLYPH_COUNT(GLYPH_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // register copy
  int          org_x       = 0;
  int          org_y       = 0;
  logic [15:0] fg_color    = '0;
  logic [15:0] fill_color  = '0;
  bit          see_through = 1'b1;
  int          cfg_len     = 0;

  // store copy, with a flag per entry telling whether it was ever loaded
  logic [7:0] string_mem [MAX_CHARS];
  bit         slot_loaded [MAX_CHARS];
  logic [7:0] glyph_mem [GLYPH_COUNT][ROWS_STORED];
  bit         row_loaded [GLYPH_COUNT][ROWS_STORED];

  tlpr_out_t pixel_q [$];
  tlpr_out_t px_front;

  int  err_cnt       = 0;
  int  results_seen  = 0;
  int  pixel_reqs    = 0;
  int  text_hits     = 0;
  int  fill_hits     = 0;
  int  store_loads   = 0;
  int  reg_writes    = 0;
  int  settings_used = 0;
  int  burst_left    = 0;
  bit  gaps_on       = 1'b1;
  int  rx_mode       = 0;
  int  rx_span       = 0;
  int  rx_hold       = 0;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    err_cnt++;
    $display("mismatch: %s at result word %0d, got %h expected %h",
             what, results_seen, got, want);
  endtask

  // is the pixel inside the string box, the string and the strip
  function automatic bit pixel_in_text(input tlpr_in_t w, output int idx,
                                       output int row, output int col);
    int len, line, x, ws, ww, rel;
    idx = 0;
    row = 0;
    col = 0;
    len = (cfg_len > MAX_CHARS) ? MAX_CHARS : cfg_len;
    line = $signed(w.scanline);
    x = $signed(w.x_pos);
    ws = $signed(w.window_start);
    ww = w.window_width;
    if (len == 0) return 1'b0;
    if (line < org_y || line > org_y + CHAR_H - 1) return 1'b0;
    if (x < org_x || x > org_x + len * CHAR_W - 1) return 1'b0;
    if (x < ws || x >= ws + ww) return 1'b0;
    rel = x - org_x;
    idx = rel / CHAR_W;
    col = rel % CHAR_W;
    row = line - org_y;
    return 1'b1;
  endfunction

  // result word for one input word; loads update the store copy
  function automatic tlpr_out_t expected_pixel(input tlpr_in_t w);
    tlpr_out_t  r;
    int         idx, row, col;
    logic [7:0] code, bits;
    logic       bit_on;
    r = '0;
    case (w.action)
      ACT_RENDER: begin
        pixel_reqs++;
        if (pixel_in_text(w, idx, row, col)) begin
          code = string_mem[idx];
          bits = 8'h00;
          if (code < GLYPH_COUNT && row < ROWS_STORED) bits = glyph_mem[code][row];
          bit_on = (col < 8) ? bits[col] : 1'b0;
          if (bit_on) begin
            r.write_pixel = 1'b1;
            r.pixel_color = fg_color;
            text_hits++;
          end else if (!see_through) begin
            r.write_pixel = 1'b1;
            r.pixel_color = fill_color;
            fill_hits++;
          end
        end
      end
      ACT_LOAD_CHAR: begin
        store_loads++;
        if (w.char_slot < MAX_CHARS) begin
          string_mem[w.char_slot] = w.char_code;
          slot_loaded[w.char_slot] = 1'b1;
        end
      end
      ACT_LOAD_GLYPH: begin
        store_loads++;
        if (w.char_code < GLYPH_COUNT) begin
          glyph_mem[w.char_code][w.glyph_row] = w.glyph_bits;
          row_loaded[w.char_code][w.glyph_row] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tlpr_in_t random_word();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(tlpr_in_t)-1:0];
  endfunction

  function automatic tlpr_in_t char_load(input int slot, input int code);
    tlpr_in_t w;
    w = random_word();
    w.action = ACT_LOAD_CHAR;
    w.char_slot = slot[5:0];
    w.char_code = code[7:0];
    return w;
  endfunction

  function automatic tlpr_in_t row_load(input int code, input int row, input int bits);
    tlpr_in_t w;
    w = random_word();
    w.action = ACT_LOAD_GLYPH;
    w.char_code = code[7:0];
    w.glyph_row = row[2:0];
    w.glyph_bits = bits[7:0];
    return w;
  endfunction

  function automatic tlpr_in_t pixel_at(input int line, input int x, input int ws,
                                        input int ww);
    tlpr_in_t w;
    w = random_word();
    w.action = ACT_RENDER;
    w.scanline = line[15:0];
    w.x_pos = x[15:0];
    w.window_start = ws[15:0];
    w.window_width = ww[12:0];
    return w;
  endfunction

  // pixel request near the string box under the current registers
  function automatic tlpr_in_t aimed_pixel();
    int len, x, line, ws, ww;
    len = (cfg_len > MAX_CHARS) ? MAX_CHARS : cfg_len;
    if (len == 0) len = 1;
    line = org_y + $urandom_range(0, CHAR_H + 1) - 1;
    x = org_x + $urandom_range(0, len * CHAR_W + 3) - 2;
    case ($urandom_range(0, 9))
      0, 1: begin
        ws = x + $urandom_range(0, 20) - 10;
        ww = $urandom_range(0, 24);
      end
      2: begin
        ws = x - $urandom_range(0, 8191);
        ww = $urandom_range(0, 8191);
      end
      default: begin
        ws = x - $urandom_range(0, 30);
        ww = (x - ws) + $urandom_range(1, 30);
      end
    endcase
    return pixel_at(line, x, ws, ww);
  endfunction

  // hold valid until accepted; bursts can end in a random gap
  task automatic send_word(input tlpr_in_t w);
    int gap;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    pixel_q.push_back(expected_pixel(w));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // loads any string or glyph entry the pixel would read before asking for it
  task automatic send_render(input tlpr_in_t w);
    int idx, row, col;
    if (pixel_in_text(w, idx, row, col)) begin
      if (!slot_loaded[idx]) send_word(char_load(idx, $urandom_range(0, 255)));
      if (!row_loaded[string_mem[idx]][row])
        send_word(row_load(string_mem[idx], row, $urandom_range(0, 255)));
    end
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixel_q.size() != 0);
  endtask

  // writes every register, then both unused indexes with junk
  task automatic program_regs(input int xo, input int yo, input int fg, input int bg,
                              input int tr, input int len);
    logic [15:0] words [8];
    int          i;
    words[0] = xo[15:0];
    words[1] = yo[15:0];
    words[2] = fg[15:0];
    words[3] = bg[15:0];
    words[4] = tr[15:0];
    words[5] = len[15:0];
    words[6] = $urandom_range(0, 65535);
    words[7] = $urandom_range(0, 65535);
    for (i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= i[CFG_IDX_W-1:0];
      cfg_wdata <= words[i];
      @(posedge clk);
      case (i[CFG_IDX_W-1:0])
        CFG_X_ORIGIN:         org_x = $signed(words[i]);
        CFG_Y_ORIGIN:         org_y = $signed(words[i]);
        CFG_TEXT_COLOR:       fg_color = words[i];
        CFG_BACKGROUND_COLOR: fill_color = words[i];
        CFG_TRANSPARENT_BG:   see_through = words[i][0];
        CFG_STRING_LENGTH:    cfg_len = words[i][6:0];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // reset registers: empty string, so nothing is drawn anywhere
  task automatic test_blank_after_reset();
    tlpr_in_t w;
    send_render(pixel_at(-32768, -32768, -32768, 8191));
    send_render(pixel_at(32767, 32767, 0, 0));
    send_render(pixel_at(0, 0, 0, 4096));
    w = '1;
    w.action = ACT_UNUSED;
    send_word(w);
  endtask

  // leftmost bit, last string pixel, box and strip edges, then opaque fill
  task automatic test_glyph_edges();
    wait_drained();
    program_regs(100, -3, 16'hFFFF, 16'h0000, 1, 2);
    send_word(char_load(0, 8'h00));
    send_word(char_load(1, 8'hFF));
    send_word(row_load(8'h00, 0, 8'h01));
    send_word(row_load(8'hFF, 7, 8'h80));
    send_render(pixel_at(-3, 100, 0, 4096));
    send_render(pixel_at(-3, 107, 100, 8));
    send_render(pixel_at(4, 115, 108, 8));
    send_render(pixel_at(-3, 99, 0, 4096));
    send_render(pixel_at(-3, 116, 0, 4096));
    send_render(pixel_at(-4, 100, 0, 4096));
    send_render(pixel_at(5, 100, 0, 4096));
    send_render(pixel_at(-3, 100, 101, 10));
    send_render(pixel_at(-3, 100, 95, 5));
    send_render(pixel_at(-3, 100, 100, 0));
    wait_drained();
    program_regs(100, -3, 16'h0000, 16'hFFFF, 0, 2);
    send_render(pixel_at(-3, 107, 100, 8));
    send_render(pixel_at(-3, 100, 100, 1));
  endtask

  // length above the string size clamps to the full string
  task automatic test_length_saturation();
    wait_drained();
    program_regs(-32768, 32760, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 16'hFFFE, 16'hFF7F);
    send_word(char_load(MAX_CHARS - 1, 8'h00));
    send_render(pixel_at(32760, -32768 + MAX_CHARS * CHAR_W - 1, -32768, 8191));
    send_render(pixel_at(32760, -32768 + MAX_CHARS * CHAR_W, -32768, 8191));
    send_render(pixel_at(32767, -32768, -32768, 1));
  endtask

  task automatic test_random_traffic(input int n_items, input int kind);
    int i, pick, slot, code;
    wait_drained();
    gaps_on = (kind % 3) != 0;
    case (kind)
      0: program_regs($urandom_range(0, 400) - 200, $urandom_range(0, 100) - 50,
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 1), $urandom_range(1, MAX_CHARS));
      1: program_regs(-32768, -32768, 16'h0000, 16'hFFFF, 0, MAX_CHARS);
      2: program_regs(32767, 32767, 16'hFFFF, 16'h0000, 1, 1);
      3: program_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
      4: program_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0);
      default: program_regs($urandom_range(0, 200) - 100, $urandom_range(0, 60) - 30,
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            0, $urandom_range(1, 16));
    endcase
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        send_render(aimed_pixel());
      end else if (pick < 72) begin
        send_word(char_load($urandom_range(0, MAX_CHARS - 1), $urandom_range(0, 255)));
      end else if (pick < 84) begin
        // mostly rows of glyphs that the string uses
        slot = $urandom_range(0, MAX_CHARS - 1);
        code = (slot_loaded[slot] && $urandom_range(0, 3) != 0) ? string_mem[slot]
                                                                 : $urandom_range(0, 255);
        send_word(row_load(code, $urandom_range(0, 7), $urandom_range(0, 255)));
      end else if (pick < 88) begin
        send_word(random_word() | {2'b11, {($bits(tlpr_in_t) - 2){1'b0}}});
      end else begin
        send_render(pixel_at($urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 8191)));
      end
    end
  endtask

  // receiver stall pattern and result word check
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(20, 120);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= (rx_span % 4) == 0;
      default: begin
        if (rx_hold != 0) begin
          out_ready <= 1'b0;
          rx_hold--;
        end else begin
          out_ready <= 1'b1;
          rx_hold = $urandom_range(4, 24);
        end
      end
    endcase

    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("word with nothing expected", out_data.pixel_color, 16'h0000);
      end else begin
        px_front = pixel_q.pop_front();
        if (out_data.write_pixel !== px_front.write_pixel)
          report_mismatch("write_pixel", {15'd0, out_data.write_pixel},
                          {15'd0, px_front.write_pixel});
        if (out_data.pixel_color !== px_front.pixel_color)
          report_mismatch("pixel_color", out_data.pixel_color, px_front.pixel_color);
      end
      results_seen++;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_blank_after_reset();
    test_glyph_edges();
    test_length_saturation();
    test_random_traffic(55, 0);
    test_random_traffic(55, 1);
    test_random_traffic(55, 2);
    test_random_traffic(55, 3);
    test_random_traffic(55, 4);
    test_random_traffic(55, 5);
    wait_drained();
    repeat (LATENCY * 4) @(posedge clk);
    $display("checked %0d result words: %0d pixel requests (%0d text, %0d fill), %0d loads",
             results_seen, pixel_reqs, text_hits, fill_hits, store_loads);
    $display("%0d register writes across %0d register settings, %0d mismatches",
             reg_writes, settings_used, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d result words still expected", pixel_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
